@@ rtl/kmc_pkg.sv @@
// Shared types and constants for the 2-D k-means clustering block.
package kmc_pkg;

    localparam int NCLU     = 16;
    localparam int CLU_W    = 4;
    localparam int KCNT_W   = 5;
    localparam int COORD_W  = 16;
    localparam int MEMBER_W = 11;
    localparam int ROUND_W  = 8;
    localparam int DIST_W   = 2 * COORD_W + 1;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 56;

    localparam logic REG_CLUSTER_COUNT = 1'b0;
    localparam logic REG_ITER_LIMIT    = 1'b1;

    localparam logic REQ_CENTER = 1'b0;
    localparam logic REQ_POINT  = 1'b1;

    localparam logic [KCNT_W-1:0]  CLUSTER_COUNT_RST = 5'd1;
    localparam logic [ROUND_W-1:0] ITER_LIMIT_RST    = 8'd50;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_LD,
        ST_DIFF,
        ST_SQ,
        ST_CMP,
        ST_ACC,
        ST_DIV,
        ST_DIVW,
        ST_RND,
        ST_OUT
    } state_t;

endpackage

@@ rtl/kmc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module kmc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/kmc_div.sv @@
// Restoring divider, one quotient bit per cycle, quotient known to fit QUO_W bits.
module kmc_div #(
    parameter int DIVIDEND_W = 27,
    parameter int DIVISOR_W  = 11,
    parameter int QUO_W      = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [QUO_W-1:0]      quotient,
    output logic                  done
);

    localparam int STEP_W = $clog2(QUO_W + 1);

    logic [DIVISOR_W-1:0] rem_reg;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [QUO_W-1:0]     lo_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIVISOR_W:0]   trial;
    logic                 fits;

    assign trial    = {rem_reg, lo_reg[QUO_W-1]};
    assign fits     = trial >= {1'b0, dvs_reg};
    assign quotient = lo_reg;
    assign done     = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
                rem_reg  <= DIVISOR_W'(dividend[DIVIDEND_W-1:QUO_W]);
                lo_reg   <= dividend[QUO_W-1:0];
                dvs_reg  <= divisor;
            end else if (busy_reg) begin
                rem_reg  <= fits ? DIVISOR_W'(trial - {1'b0, dvs_reg})
                                 : trial[DIVISOR_W-1:0];
                lo_reg   <= {lo_reg[QUO_W-2:0], fits};
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(QUO_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

@@ rtl/kmeans_2d_clustering_top.sv @@
// Lloyd k-means on 2-D points: load sequencer, assignment loop and recentering.
// Centers and points load while idle; after the last point each round runs the
// distance loop over every point and cluster, then the two bit-serial dividers per
// non-empty cluster; finally K results leave one per accepted cycle.
// Throughput: one load request per cycle; no requests are taken while clustering.
// Reset: synchronous active-low; centers, sums, counts and fill count clear to zero.
module kmeans_2d_clustering_top #(
    parameter int MAX_POINTS = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [kmc_pkg::IN_W-1:0]    s_tdata,  // center_index, coord_x, coord_y
    input  logic                        s_tuser,  // req_type
    input  logic                        s_tlast,  // last_point
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // cluster_index, center_x, center_y, member_count, converged, rounds_used
    output logic [kmc_pkg::OUT_W-1:0]   m_tdata,
    output logic                        m_tlast,
    input  logic                        cfg_wr_en,
    input  logic                        cfg_addr,
    input  logic [7:0]                  cfg_wr_data
);

    import kmc_pkg::*;

    localparam int PTR_W = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SUM_W = COORD_W + CNT_W;

    state_t state_reg, state_next;

    logic [KCNT_W-1:0]    cluster_count_reg;
    logic [ROUND_W-1:0]   iteration_limit_reg;
    logic [KCNT_W-1:0]    k_reg;
    logic [ROUND_W-1:0]   limit_reg;
    logic [CNT_W-1:0]     loaded_reg;
    logic [CNT_W-1:0]     p_reg;
    logic [CLU_W-1:0]     c_reg;
    logic [ROUND_W-1:0]   round_reg;
    logic                 still_reg;

    logic [COORD_W-1:0]   cx_reg [NCLU];
    logic [COORD_W-1:0]   cy_reg [NCLU];
    logic [SUM_W-1:0]     sx_reg [NCLU];
    logic [SUM_W-1:0]     sy_reg [NCLU];
    logic [CNT_W-1:0]     cnt_reg [NCLU];

    logic [COORD_W-1:0]   px_reg, py_reg;
    logic [COORD_W-1:0]   dx_reg, dy_reg;
    logic [2*COORD_W-1:0] dxx_reg, dyy_reg;
    logic [DIST_W-1:0]    best_d_reg;
    logic [CLU_W-1:0]     best_reg;

    logic                 in_acc;
    logic                 full;
    logic                 c_last;
    logic                 p_last;
    logic                 lim_hit;
    logic [DIST_W-1:0]    dist_sum;
    logic [KCNT_W-1:0]    k_eff;
    logic [ROUND_W-1:0]   limit_eff;

    logic                 ram_wr;
    logic                 ram_rd;
    logic [2*COORD_W-1:0] ram_q;
    logic                 div_start;
    logic [COORD_W-1:0]   qx, qy;
    logic                 qx_done, qy_done;

    assign in_acc    = s_tvalid && s_tready;
    assign full      = loaded_reg == CNT_W'(MAX_POINTS);
    assign c_last    = ({1'b0, c_reg} + 1'b1) == k_reg;
    assign p_last    = (p_reg + 1'b1) == loaded_reg;
    assign lim_hit   = (round_reg + 1'b1) == limit_reg;
    assign dist_sum  = {1'b0, dxx_reg} + {1'b0, dyy_reg};
    assign k_eff     = (cluster_count_reg == '0) ? KCNT_W'(1) :
                       (cluster_count_reg > KCNT_W'(NCLU)) ? KCNT_W'(NCLU) :
                       cluster_count_reg;
    assign limit_eff = (iteration_limit_reg == '0) ? ROUND_W'(1) : iteration_limit_reg;

    kmc_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (MAX_POINTS)
    ) u_points (
        .aclk    (aclk),
        .wr_en   (ram_wr),
        .wr_addr (loaded_reg[PTR_W-1:0]),
        .wr_data (s_tdata[35:4]),
        .rd_en   (ram_rd),
        .rd_addr (p_reg[PTR_W-1:0]),
        .rd_data (ram_q)
    );

    kmc_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W),
        .QUO_W      (COORD_W)
    ) u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sx_reg[c_reg]),
        .divisor  (cnt_reg[c_reg]),
        .quotient (qx),
        .done     (qx_done)
    );

    kmc_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W),
        .QUO_W      (COORD_W)
    ) u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sy_reg[c_reg]),
        .divisor  (cnt_reg[c_reg]),
        .quotient (qy),
        .done     (qy_done)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_acc && s_tuser == REQ_POINT && s_tlast) begin
                    state_next = ST_RD;
                end
            end
            ST_RD:   state_next = ST_LD;
            ST_LD:   state_next = ST_DIFF;
            ST_DIFF: state_next = ST_SQ;
            ST_SQ:   state_next = ST_CMP;
            ST_CMP:  state_next = c_last ? ST_ACC : ST_DIFF;
            ST_ACC:  state_next = p_last ? ST_DIV : ST_RD;
            ST_DIV: begin
                if (cnt_reg[c_reg] != '0) begin
                    state_next = ST_DIVW;
                end else if (c_last) begin
                    state_next = ST_RND;
                end
            end
            ST_DIVW: begin
                if (qx_done) begin
                    state_next = c_last ? ST_RND : ST_DIV;
                end
            end
            ST_RND:  state_next = (still_reg || lim_hit) ? ST_OUT : ST_RD;
            ST_OUT: begin
                if (m_tready && c_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        ram_rd    = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            ST_IDLE: s_tready  = 1'b1;
            ST_RD:   ram_rd    = 1'b1;
            ST_DIV:  div_start = cnt_reg[c_reg] != '0;
            ST_OUT:  m_tvalid  = 1'b1;
            default: ;
        endcase
        ram_wr = in_acc && s_tuser == REQ_POINT && !full;
    end

    assign m_tdata = {round_reg, still_reg, MEMBER_W'(cnt_reg[c_reg]),
                      cy_reg[c_reg], cx_reg[c_reg], c_reg};
    assign m_tlast = c_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= ST_IDLE;
            cluster_count_reg   <= CLUSTER_COUNT_RST;
            iteration_limit_reg <= ITER_LIMIT_RST;
            loaded_reg          <= '0;
            round_reg           <= '0;
            still_reg           <= 1'b0;
            for (int i = 0; i < NCLU; i++) begin
                cx_reg[i]  <= '0;
                cy_reg[i]  <= '0;
                sx_reg[i]  <= '0;
                sy_reg[i]  <= '0;
                cnt_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_CLUSTER_COUNT: cluster_count_reg   <= cfg_wr_data[KCNT_W-1:0];
                    REG_ITER_LIMIT:    iteration_limit_reg <= cfg_wr_data;
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE: begin
                    if (in_acc) begin
                        if (s_tuser == REQ_CENTER) begin
                            cx_reg[s_tdata[3:0]] <= s_tdata[19:4];
                            cy_reg[s_tdata[3:0]] <= s_tdata[35:20];
                        end else begin
                            if (!full) begin
                                loaded_reg <= loaded_reg + 1'b1;
                            end
                            if (s_tlast) begin
                                k_reg     <= k_eff;
                                limit_reg <= limit_eff;
                                round_reg <= '0;
                                p_reg     <= '0;
                                for (int i = 0; i < NCLU; i++) begin
                                    sx_reg[i]  <= '0;
                                    sy_reg[i]  <= '0;
                                    cnt_reg[i] <= '0;
                                end
                            end
                        end
                    end
                end
                ST_LD: begin
                    px_reg <= ram_q[COORD_W-1:0];
                    py_reg <= ram_q[2*COORD_W-1:COORD_W];
                    c_reg  <= '0;
                end
                ST_DIFF: begin
                    dx_reg <= (px_reg >= cx_reg[c_reg]) ? px_reg - cx_reg[c_reg]
                                                        : cx_reg[c_reg] - px_reg;
                    dy_reg <= (py_reg >= cy_reg[c_reg]) ? py_reg - cy_reg[c_reg]
                                                        : cy_reg[c_reg] - py_reg;
                end
                ST_SQ: begin
                    dxx_reg <= dx_reg * dx_reg;
                    dyy_reg <= dy_reg * dy_reg;
                end
                ST_CMP: begin
                    if (c_reg == '0 || dist_sum < best_d_reg) begin
                        best_d_reg <= dist_sum;
                        best_reg   <= c_reg;
                    end
                    c_reg <= c_reg + 1'b1;
                end
                ST_ACC: begin
                    sx_reg[best_reg]  <= sx_reg[best_reg] + SUM_W'(px_reg);
                    sy_reg[best_reg]  <= sy_reg[best_reg] + SUM_W'(py_reg);
                    cnt_reg[best_reg] <= cnt_reg[best_reg] + 1'b1;
                    p_reg             <= p_reg + 1'b1;
                    c_reg             <= '0;
                    still_reg         <= 1'b1;
                end
                ST_DIV: begin
                    if (cnt_reg[c_reg] == '0 && !c_last) begin
                        c_reg <= c_reg + 1'b1;
                    end
                end
                ST_DIVW: begin
                    if (qx_done && qy_done) begin
                        if (qx != cx_reg[c_reg] || qy != cy_reg[c_reg]) begin
                            still_reg <= 1'b0;
                        end
                        cx_reg[c_reg] <= qx;
                        cy_reg[c_reg] <= qy;
                        if (!c_last) begin
                            c_reg <= c_reg + 1'b1;
                        end
                    end
                end
                ST_RND: begin
                    round_reg <= round_reg + 1'b1;
                    c_reg     <= '0;
                    if (!still_reg && !lim_hit) begin
                        p_reg <= '0;
                        for (int i = 0; i < NCLU; i++) begin
                            sx_reg[i]  <= '0;
                            sy_reg[i]  <= '0;
                            cnt_reg[i] <= '0;
                        end
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        if (c_last) begin
                            loaded_reg <= '0;
                        end else begin
                            c_reg <= c_reg + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

@@ verif/kmc_checker.sv @@
// Checker for the k-means block: tracks loads and register writes, predicts and compares results.
module kmc_checker (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [kmc_pkg::IN_W-1:0]  s_tdata,
    input  logic                      s_tuser,
    input  logic                      s_tlast,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [kmc_pkg::OUT_W-1:0] m_tdata,
    input  logic                      m_tlast,
    input  logic                      cfg_wr_en,
    input  logic                      cfg_addr,
    input  logic [7:0]                cfg_wr_data,
    output int                        errors,
    output int                        pending
);
    import kmc_pkg::*;

    localparam int STORE_DEPTH = 1024;

    typedef struct {
        logic [CLU_W-1:0]    idx;
        logic [COORD_W-1:0]  cx;
        logic [COORD_W-1:0]  cy;
        logic [MEMBER_W-1:0] members;
        logic                conv;
        logic [ROUND_W-1:0]  rounds;
        logic                fin;
    } cluster_result_t;

    cluster_result_t       results_due[$];
    logic [COORD_W-1:0]    pts_x[STORE_DEPTH];
    logic [COORD_W-1:0]    pts_y[STORE_DEPTH];
    logic [COORD_W-1:0]    ctr_x[NCLU];
    logic [COORD_W-1:0]    ctr_y[NCLU];
    int unsigned           n_loaded;
    logic [KCNT_W-1:0]     k_reg;
    logic [ROUND_W-1:0]    lim_reg;

    assign pending = results_due.size();

    task automatic report(string what, longint got, longint want);
        $display("kmc_checker: %s got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic longint unsigned sq_gap(logic [COORD_W-1:0] ax, logic [COORD_W-1:0] ay,
                                               logic [COORD_W-1:0] bx, logic [COORD_W-1:0] by);
        longint unsigned dx, dy;
        dx = (ax >= bx) ? longint'(ax - bx) : longint'(bx - ax);
        dy = (ay >= by) ? longint'(ay - by) : longint'(by - ay);
        return dx * dx + dy * dy;
    endfunction

    // Lloyd rounds over the stored set, then one result per cluster in use
    task automatic run_lloyd();
        longint unsigned sx[NCLU], sy[NCLU], d, bd;
        int unsigned     cnt[NCLU];
        int unsigned     k, lim, rounds, best;
        logic [COORD_W-1:0] nx, ny;
        bit still;
        cluster_result_t r;
        k = (k_reg == 0) ? 1 : (k_reg > NCLU) ? NCLU : 32'(k_reg);
        lim = (lim_reg == 0) ? 1 : 32'(lim_reg);
        rounds = 0;
        still = 0;
        while (!still && rounds < lim) begin
            for (int c = 0; c < NCLU; c++) begin
                sx[c] = 0; sy[c] = 0; cnt[c] = 0;
            end
            for (int p = 0; p < n_loaded; p++) begin
                best = 0;
                bd = sq_gap(pts_x[p], pts_y[p], ctr_x[0], ctr_y[0]);
                for (int c = 1; c < k; c++) begin
                    d = sq_gap(pts_x[p], pts_y[p], ctr_x[c], ctr_y[c]);
                    if (d < bd) begin
                        bd = d;
                        best = c;
                    end
                end
                sx[best] += 64'(pts_x[p]);
                sy[best] += 64'(pts_y[p]);
                cnt[best]++;
            end
            still = 1;
            for (int c = 0; c < k; c++) begin
                if (cnt[c] != 0) begin
                    nx = COORD_W'(sx[c] / cnt[c]);
                    ny = COORD_W'(sy[c] / cnt[c]);
                    if (nx != ctr_x[c] || ny != ctr_y[c]) still = 0;
                    ctr_x[c] = nx;
                    ctr_y[c] = ny;
                end
            end
            rounds++;
        end
        for (int c = 0; c < k; c++) begin
            r.idx = CLU_W'(c);
            r.cx = ctr_x[c];
            r.cy = ctr_y[c];
            r.members = MEMBER_W'(cnt[c]);
            r.conv = still;
            r.rounds = ROUND_W'(rounds);
            r.fin = (c + 1 == k);
            results_due = {results_due, r};
        end
        n_loaded = 0;
    endtask

    always @(posedge aclk) begin
        cluster_result_t w;
        if (!aresetn) begin
            errors = 0;
            results_due.delete();
            n_loaded = 0;
            k_reg = CLUSTER_COUNT_RST;
            lim_reg = ITER_LIMIT_RST;
            for (int c = 0; c < NCLU; c++) begin
                ctr_x[c] = '0;
                ctr_y[c] = '0;
            end
        end else begin
            if (cfg_wr_en) begin
                if (cfg_addr == REG_CLUSTER_COUNT) k_reg = cfg_wr_data[KCNT_W-1:0];
                else lim_reg = cfg_wr_data;
            end
            if (m_tvalid && m_tready) begin
                if (results_due.size() == 0) begin
                    report("unexpected result, cluster", m_tdata[3:0], -1);
                end else begin
                    w = results_due.pop_front();
                    if (m_tdata[3:0] != w.idx) report("cluster_index", m_tdata[3:0], w.idx);
                    if (m_tdata[19:4] != w.cx) report("center_x", m_tdata[19:4], w.cx);
                    if (m_tdata[35:20] != w.cy) report("center_y", m_tdata[35:20], w.cy);
                    if (m_tdata[46:36] != w.members)
                        report("member_count", m_tdata[46:36], w.members);
                    if (m_tdata[47] != w.conv) report("converged", m_tdata[47], w.conv);
                    if (m_tdata[55:48] != w.rounds) report("rounds_used", m_tdata[55:48], w.rounds);
                    if (m_tlast != w.fin) report("tlast", m_tlast, w.fin);
                end
            end
            if (s_tvalid && s_tready) begin
                if (s_tuser == REQ_CENTER) begin
                    ctr_x[s_tdata[3:0]] = s_tdata[19:4];
                    ctr_y[s_tdata[3:0]] = s_tdata[35:20];
                end else begin
                    if (n_loaded < STORE_DEPTH) begin
                        pts_x[n_loaded] = s_tdata[19:4];
                        pts_y[n_loaded] = s_tdata[35:20];
                        n_loaded++;
                    end
                    if (s_tlast) run_lloyd();
                end
            end
        end
    end
endmodule

@@ verif/tb_top.sv @@
// Testbench top for the k-means block: clock, reset, stimulus, idling and verdict.
module tb_top;
    import kmc_pkg::*;

    logic                aclk;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_W-1:0]     s_tdata;   // center_index, coord_x, coord_y
    logic                s_tuser;   // req_type
    logic                s_tlast;   // last_point
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_W-1:0]    m_tdata;   // cluster_index, center_x, center_y, member_count,
                                    // converged, rounds_used
    logic                m_tlast;
    logic                cfg_wr_en;
    logic                cfg_addr;
    logic [7:0]          cfg_wr_data;
    int                  errors;
    int                  pending;
    int                  tx_idle;
    int                  rx_idle;
    int                  hold_cycles;
    int                  sent;

    kmeans_2d_clustering_top i_dut (.*);

    kmc_checker i_chk (.*);

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    initial begin
        #1_000_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // result side: random stalls plus an optional long hold-off
    initial begin
        m_tready = 0;
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle);
            end
        end
    end

    task automatic send(logic req, logic [3:0] idx, logic [15:0] x, logic [15:0] y, logic lst);
        while ($urandom_range(99) < tx_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {4'b0, y, x, idx};
        s_tlast <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(logic addr, logic [7:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // blob-shaped set with random centers reloaded first, a stray center load now and then
    task automatic random_set();
        logic [15:0] bx[4], by[4];
        int n, nc, b;
        n = $urandom_range(1, 24);
        nc = $urandom_range(0, 6);
        for (int i = 0; i < 4; i++) begin
            bx[i] = 16'($urandom);
            by[i] = 16'($urandom);
        end
        for (int i = 0; i < nc; i++)
            send(REQ_CENTER, 4'($urandom_range(15)), 16'($urandom), 16'($urandom),
                 1'($urandom_range(1)));
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(19) == 0)
                send(REQ_CENTER, 4'($urandom_range(15)), 16'($urandom), 16'($urandom), 1'b0);
            b = $urandom_range(3);
            if ($urandom_range(4) == 0)
                send(REQ_POINT, 4'($urandom_range(15)), 16'($urandom), 16'($urandom),
                     i == n - 1);
            else
                send(REQ_POINT, 4'($urandom_range(15)), 16'(bx[b] ^ ($urandom & 16'h0fff)),
                     16'(by[b] ^ ($urandom & 16'h0fff)), i == n - 1);
        end
    endtask

    initial begin
        int kpick[6];
        int lpick[4];
        bit held;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = 0;
        s_tlast = 0;
        cfg_wr_en = 0;
        cfg_addr = REG_CLUSTER_COUNT;
        cfg_wr_data = '0;
        tx_idle = 25;
        rx_idle = 82;
        hold_cycles = 0;
        sent = 0;
        held = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: one cluster, zero center
        send(REQ_POINT, 4'd0, 16'hffff, 16'h0000, 1'b0);
        send(REQ_POINT, 4'd15, 16'h0001, 16'hffff, 1'b1);
        wait_idle();
        // ties, empty cluster, extremes
        write_reg(REG_CLUSTER_COUNT, 8'd4);
        write_reg(REG_ITER_LIMIT, 8'd255);
        send(REQ_CENTER, 4'd0, 16'h0000, 16'h0000, 1'b0);
        send(REQ_CENTER, 4'd1, 16'hffff, 16'hffff, 1'b0);
        send(REQ_CENTER, 4'd2, 16'h0000, 16'h0000, 1'b0);
        send(REQ_CENTER, 4'd3, 16'hffff, 16'h0000, 1'b1);
        send(REQ_CENTER, 4'd15, 16'h8000, 16'h8000, 1'b0);
        send(REQ_POINT, 4'd0, 16'h0000, 16'h0000, 1'b0);
        send(REQ_POINT, 4'd0, 16'h0001, 16'h0001, 1'b0);
        send(REQ_POINT, 4'd0, 16'hffff, 16'hffff, 1'b0);
        send(REQ_POINT, 4'd0, 16'h8000, 16'h8000, 1'b0);
        send(REQ_POINT, 4'd0, 16'hfffe, 16'hffff, 1'b1);
        // single point reuses final centers
        send(REQ_POINT, 4'd0, 16'h7fff, 16'h0000, 1'b1);
        wait_idle();
        write_reg(REG_ITER_LIMIT, 8'd0);
        write_reg(REG_CLUSTER_COUNT, 8'd0);
        send(REQ_POINT, 4'd0, 16'h1234, 16'h4321, 1'b0);
        send(REQ_POINT, 4'd0, 16'hedcb, 16'hbcde, 1'b1);
        wait_idle();

        kpick = '{1, 16, 0, 31, 17, 0};
        lpick = '{1, 255, 0, 0};
        while (sent < 360) begin
            if (sent > 240) begin
                tx_idle = 0;
                rx_idle = 0;
            end else if (sent > 120) begin
                tx_idle = 82;
                rx_idle = 25;
            end
            // long result hold-off while the next set keeps coming
            if (sent > 240 && !held) begin
                held = 1'b1;
                wait_idle();
                write_reg(REG_CLUSTER_COUNT, 8'd4);
                write_reg(REG_ITER_LIMIT, 8'd4);
                hold_cycles = 3000;
                random_set();
                random_set();
            end
            if ($urandom_range(2) == 0) begin
                wait_idle();
                kpick[5] = $urandom_range(2, 15);
                lpick[3] = $urandom_range(2, 254);
                write_reg(REG_CLUSTER_COUNT, 8'(kpick[$urandom_range(5)]));
                write_reg(REG_ITER_LIMIT, 8'(lpick[$urandom_range(3)]));
            end
            random_set();
        end
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
